[design/frame_rate_meter_limiter_unit_defines.svh]
// Assertion macros for the frame rate meter and limiter.
// Define ASSERT_OFF to compile the checks away.
`ifndef FRAME_RATE_METER_LIMITER_UNIT_DEFINES_SVH
`define FRAME_RATE_METER_LIMITER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Clocked check that is switched off while reset is asserted.
`define FRMLU_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define FRMLU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FRMLU_ASSERT_RST(lbl, clk, rst_n, prop, msg)
`define FRMLU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

[design/frmlu_pkg.sv]
package frmlu_pkg;

    // Ring of recent frame intervals.
    localparam int WINDOW = 10;
    localparam int POS_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);

    // Field widths.
    localparam int TS_W   = 32;
    localparam int INTV_W = 16;
    localparam int FPS_W  = 22;
    localparam int DLY_W  = 10;
    localparam int CFG_W  = 10;
    localparam int SUM_W  = INTV_W + CNT_W;

    // Arithmetic constants.
    localparam logic [INTV_W-1:0] INTV_MAX        = '1;
    localparam int                FPS_SCALE       = 1000 * 256;
    localparam logic [FPS_W-1:0]  FPS_FALLBACK_Q8 = FPS_W'(60 * 256);
    localparam int                BUDGET_MS       = 1000;
    localparam int                BUDGET_SHIFT    = FPS_W - DLY_W;
    localparam int                DIV_CNT_W       = $clog2(FPS_W + 1);
    localparam logic [CFG_W-1:0]  MAX_FPS_RESET   = CFG_W'(60);

    // Request kinds carried in tuser.
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_END   = 1'b1;

    // Configuration port.
    localparam int   APB_ADDR_W  = 3;
    localparam int   APB_DATA_W  = 32;
    localparam logic REG_MAX_FPS = 1'b0;

endpackage

[design/frame_rate_meter_limiter_unit.sv]
// Channel  | Direction | Payload                                   | Handshake
// s_       | in        | tdata: now_ms; tuser: req_type            | s_tvalid / s_tready
// m_       | out       | tdata: fps_q8 [21:0], delay_ms [31:22]    | m_tvalid / m_tready
// APB      | in        | max_fps at byte address 0                 | psel / penable / pready
//
// A frame-start item leaves the block idle, so it is ready for the next item at once.
// A frame-end item sums the N filled ring entries (at most 10) through the ring's
// registered read port, then one shared bit-serial divider runs 22 steps for the rate
// (skipped for an all-zero window) and 10 for the budget.
// Reset is synchronous and active low; it clears all event history and sets max_fps to 60.
// A finished result waits in the output register while new items are taken; the next
// result holds the block until that register is free.
`include "frame_rate_meter_limiter_unit_defines.svh"

module frame_rate_meter_limiter_unit
    import frmlu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input item channel.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [TS_W-1:0]       s_tdata,   // [31:0] now_ms
    input  logic                  s_tuser,   // [0] req_type
    // Result item channel.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [21:0] fps_q8, [31:22] delay_ms
    // Configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef enum logic {
        PH_FPS,
        PH_BUDGET
    } div_phase_t;

    state_t                 state_reg, state_next;
    div_phase_t             phase_reg, phase_next;
    logic [CFG_W-1:0]       max_fps_reg, max_fps_next;
    logic [TS_W-1:0]        start_time_reg, start_time_next;
    logic [TS_W-1:0]        prev_end_reg, prev_end_next;
    logic                   have_prev_reg, have_prev_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic                   rd_valid_reg, rd_valid_next;
    logic [INTV_W-1:0]      rd_data_reg;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [TS_W-1:0]        frame_reg, frame_next;
    logic [FPS_W-1:0]       fps_reg, fps_next;
    logic [FPS_W-1:0]       div_num_reg, div_num_next;
    logic [SUM_W-1:0]       div_rem_reg, div_rem_next;
    logic [SUM_W-1:0]       div_den_reg, div_den_next;
    logic [FPS_W-1:0]       div_quo_reg, div_quo_next;
    logic [DIV_CNT_W-1:0]   div_cnt_reg, div_cnt_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [31:0]            m_tdata_reg, m_tdata_next;

    logic [INTV_W-1:0]      ring_mem [WINDOW];

    logic                   in_fire;
    logic                   end_fire;
    logic                   apb_wr;
    logic [TS_W-1:0]        since_prev;
    logic [INTV_W-1:0]      intv;
    logic                   rd_en;
    logic [SUM_W:0]         trial;
    logic [SUM_W:0]         trial_diff;
    logic                   trial_ge;
    logic [SUM_W-1:0]       rem_step;
    logic [FPS_W-1:0]       quo_step;
    logic [CFG_W-1:0]       rate;
    logic [DLY_W-1:0]       budget;
    logic [DLY_W-1:0]       delay;

    // Handshakes and configuration access.
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign end_fire = in_fire && (s_tuser == REQ_END);
    assign pready   = 1'b1;
    assign apb_wr   = psel && penable && pwrite && pready
                      && (paddr[APB_ADDR_W-1] == REG_MAX_FPS);
    assign prdata   = (paddr[APB_ADDR_W-1] == REG_MAX_FPS) ?
                      APB_DATA_W'(max_fps_reg) : '0;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Interval since the previous end event, saturated, zero for the first one.
    assign since_prev = s_tdata - prev_end_reg;
    assign intv = !have_prev_reg        ? '0 :
                  (|since_prev[TS_W-1:INTV_W]) ? INTV_MAX : since_prev[INTV_W-1:0];

    // The ring is read one filled entry per cycle while summing.
    assign rd_en = (state_reg == ST_SUM) && (idx_reg < count_reg);

    // One restoring division step: one quotient bit per cycle.
    assign trial      = {div_rem_reg, div_num_reg[FPS_W-1]};
    assign trial_diff = trial - {1'b0, div_den_reg};
    assign trial_ge   = (trial >= {1'b0, div_den_reg});
    assign rem_step   = trial_ge ? trial_diff[SUM_W-1:0] : trial[SUM_W-1:0];
    assign quo_step   = {div_quo_reg[FPS_W-2:0], trial_ge};

    // Zero max_fps counts as one frame per second.
    assign rate = (max_fps_reg == '0) ? CFG_W'(1) : max_fps_reg;

    // Delay from the budget held in the quotient after the second division.
    assign budget = div_quo_reg[DLY_W-1:0];
    assign delay  = (frame_reg >= TS_W'(budget)) ? '0 : (budget - frame_reg[DLY_W-1:0]);

    // Next-state logic of the sequencer.
    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        max_fps_next    = apb_wr ? pwdata[CFG_W-1:0] : max_fps_reg;
        start_time_next = start_time_reg;
        prev_end_next   = prev_end_reg;
        have_prev_next  = have_prev_reg;
        pos_next        = pos_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        rd_valid_next   = 1'b0;
        sum_next        = sum_reg;
        frame_next      = frame_reg;
        fps_next        = fps_reg;
        div_num_next    = div_num_reg;
        div_rem_next    = div_rem_reg;
        div_den_next    = div_den_reg;
        div_quo_next    = div_quo_reg;
        div_cnt_next    = div_cnt_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire && (s_tuser == REQ_START)) begin
                    start_time_next = s_tdata;
                end
                if (end_fire) begin
                    prev_end_next  = s_tdata;
                    have_prev_next = 1'b1;
                    frame_next     = s_tdata - start_time_reg;
                    pos_next       = (pos_reg == POS_W'(WINDOW - 1)) ? '0 : pos_reg + 1'b1;
                    count_next     = (count_reg == CNT_W'(WINDOW)) ? count_reg
                                                                   : count_reg + 1'b1;
                    idx_next       = '0;
                    sum_next       = '0;
                    state_next     = ST_SUM;
                end
            end

            ST_SUM: begin
                // Accumulate the entry read in the previous cycle.
                if (rd_valid_reg) begin
                    sum_next = sum_reg + SUM_W'(rd_data_reg);
                end
                if (rd_en) begin
                    idx_next = idx_reg + 1'b1;
                end
                rd_valid_next = rd_en;
                if (!rd_en && !rd_valid_reg) begin
                    div_rem_next = '0;
                    div_quo_next = '0;
                    state_next   = ST_DIV;
                    if (sum_reg == '0) begin
                        // No measured time yet: report the fallback rate.
                        fps_next     = FPS_FALLBACK_Q8;
                        phase_next   = PH_BUDGET;
                        div_num_next = FPS_W'(BUDGET_MS) << BUDGET_SHIFT;
                        div_den_next = SUM_W'(rate);
                        div_cnt_next = DIV_CNT_W'(DLY_W);
                    end else begin
                        phase_next   = PH_FPS;
                        div_num_next = FPS_W'(count_reg) * FPS_W'(FPS_SCALE);
                        div_den_next = sum_reg;
                        div_cnt_next = DIV_CNT_W'(FPS_W);
                    end
                end
            end

            ST_DIV: begin
                div_num_next = div_num_reg << 1;
                div_rem_next = rem_step;
                div_quo_next = quo_step;
                div_cnt_next = div_cnt_reg - 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(1)) begin
                    if (phase_reg == PH_FPS) begin
                        // Rate done; start the frame budget division.
                        fps_next     = quo_step;
                        phase_next   = PH_BUDGET;
                        div_num_next = FPS_W'(BUDGET_MS) << BUDGET_SHIFT;
                        div_rem_next = '0;
                        div_quo_next = '0;
                        div_den_next = SUM_W'(rate);
                        div_cnt_next = DIV_CNT_W'(DLY_W);
                    end else begin
                        state_next = ST_DONE;
                    end
                end
            end

            ST_DONE: begin
                // Hand the item over once the output register is free.
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {delay, fps_reg};
                    state_next    = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_FPS;
            max_fps_reg    <= MAX_FPS_RESET;
            start_time_reg <= '0;
            prev_end_reg   <= '0;
            have_prev_reg  <= 1'b0;
            pos_reg        <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            rd_valid_reg   <= 1'b0;
            div_cnt_reg    <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            max_fps_reg    <= max_fps_next;
            start_time_reg <= start_time_next;
            prev_end_reg   <= prev_end_next;
            have_prev_reg  <= have_prev_next;
            pos_reg        <= pos_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            rd_valid_reg   <= rd_valid_next;
            div_cnt_reg    <= div_cnt_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        sum_reg     <= sum_next;
        frame_reg   <= frame_next;
        fps_reg     <= fps_next;
        div_num_reg <= div_num_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
        div_quo_reg <= div_quo_next;
        m_tdata_reg <= m_tdata_next;
    end

    // Interval ring: written on an end item, read with a registered port.
    always_ff @(posedge aclk) begin
        if (end_fire) begin
            ring_mem[pos_reg] <= intv;
        end
        if (rd_en) begin
            rd_data_reg <= ring_mem[idx_reg[POS_W-1:0]];
        end
    end

    // An end item always starts the ring sum.
    `FRMLU_ASSERT_RST(a_end_starts_sum, aclk, aresetn, end_fire |=> (state_reg == ST_SUM), "end item did not start the ring sum")
    // Away from idle the fill count is between one and the window size.
    `FRMLU_ASSERT_RST(a_fill_in_range, aclk, aresetn, (state_reg != ST_IDLE) |-> ((count_reg != '0) && (count_reg <= CNT_W'(WINDOW))), "fill count out of range while busy")
    // A pending result is never overwritten by the next one.
    `FRMLU_ASSERT_RST(a_no_overwrite, aclk, aresetn, ((state_reg == ST_DONE) && m_tvalid_reg && !m_tready) |=> ((state_reg == ST_DONE) && $stable(m_tdata_reg)), "pending result overwritten")
    // The ring position stays inside the window whenever reset is not asserted.
    `FRMLU_ASSERT_ALWAYS(a_pos_in_range, aclk, !aresetn || (pos_reg < POS_W'(WINDOW)) || (WINDOW == (1 << POS_W)), "ring position out of range")

endmodule

[sim/frame_rate_meter_limiter_checker.sv]
`timescale 1ns / 100ps

module frame_rate_meter_limiter_checker
    import frmlu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [TS_W-1:0]       s_tdata,   // [31:0] now_ms
    input  logic                  s_tuser,   // [0] req_type
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [31:0]           m_tdata,   // [21:0] fps_q8, [31:22] delay_ms
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,
    output int                    mismatch_count,
    output int                    pending_count
);

    localparam logic [APB_ADDR_W-1:0] MAX_FPS_ADDR = {REG_MAX_FPS, 2'b00};

    typedef struct packed {
        logic [FPS_W-1:0] fps_q8;
        logic [DLY_W-1:0] delay_ms;
    } frame_rate_t;

    // Shadow of the meter state and the rate limit register.
    logic [CFG_W-1:0]  fps_limit;
    logic [TS_W-1:0]   frame_start_ts;
    logic [TS_W-1:0]   last_end_ts;
    logic              have_last;
    logic [INTV_W-1:0] interval_ring [WINDOW];
    int unsigned       ring_wr;
    int unsigned       ring_fill;
    frame_rate_t       rate_expect_q [$];

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: frame rate mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Records one frame-end item and queues the rate and delay it must produce.
    task automatic log_frame_end(input logic [TS_W-1:0] ts);
        logic [TS_W-1:0]   span;
        logic [INTV_W-1:0] intv;
        longint unsigned   sum;
        int unsigned       rate;
        int unsigned       budget;
        logic [TS_W-1:0]   frame_ms;
        frame_rate_t       r;
        intv = '0;
        if (have_last) begin
            span = ts - last_end_ts;
            intv = (span > TS_W'(INTV_MAX)) ? INTV_MAX : span[INTV_W-1:0];
        end
        interval_ring[ring_wr] = intv;
        ring_wr = (ring_wr + 1) % WINDOW;
        if (ring_fill < WINDOW) ring_fill++;
        last_end_ts = ts;
        have_last   = 1'b1;

        // Average over the filled entries; an all-zero window falls back to 60 fps.
        sum = 0;
        for (int i = 0; i < ring_fill; i++) sum += interval_ring[i];
        if (sum == 0) begin
            r.fps_q8 = FPS_FALLBACK_Q8;
        end else begin
            r.fps_q8 = FPS_W'((64'(FPS_SCALE) * ring_fill) / sum);
        end

        // A zero limit counts as one frame per second.
        rate     = (fps_limit == '0) ? 1 : fps_limit;
        budget   = BUDGET_MS / rate;
        frame_ms = ts - frame_start_ts;
        r.delay_ms = (frame_ms >= budget) ? '0 : DLY_W'(budget - frame_ms);
        rate_expect_q.push_back(r);
    endtask

    always @(posedge aclk) begin
        frame_rate_t want;
        if (!aresetn) begin
            fps_limit      = MAX_FPS_RESET;
            frame_start_ts = '0;
            last_end_ts    = '0;
            have_last      = 1'b0;
            ring_wr        = 0;
            ring_fill      = 0;
            for (int i = 0; i < WINDOW; i++) interval_ring[i] = '0;
            rate_expect_q.delete();
        end else begin
            // Register writes and read-back.
            if (psel && penable && pready && paddr == MAX_FPS_ADDR) begin
                if (pwrite) begin
                    fps_limit = pwdata[CFG_W-1:0];
                end else if (prdata !== APB_DATA_W'(fps_limit)) begin
                    report_mismatch($sformatf("max_fps read %0d, expected %0d",
                                              prdata, fps_limit));
                end
            end

            // Result items against the oldest expectation.
            if (m_tvalid && m_tready) begin
                if (rate_expect_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result item %h", m_tdata));
                end else begin
                    want = rate_expect_q.pop_front();
                    if (m_tdata[FPS_W-1:0] !== want.fps_q8)
                        report_mismatch($sformatf("fps_q8 %0d, expected %0d",
                                                  m_tdata[FPS_W-1:0], want.fps_q8));
                    if (m_tdata[FPS_W +: DLY_W] !== want.delay_ms)
                        report_mismatch($sformatf("delay_ms %0d, expected %0d",
                                                  m_tdata[FPS_W +: DLY_W], want.delay_ms));
                end
            end

            // Input items update the shadow state.
            if (s_tvalid && s_tready) begin
                if (s_tuser == REQ_START) begin
                    frame_start_ts = s_tdata;
                end else begin
                    log_frame_end(s_tdata);
                end
            end
        end
        pending_count <= rate_expect_q.size();
    end

endmodule

[sim/tb_frame_rate_meter_limiter_unit.sv]
`timescale 1ns / 100ps

module tb_frame_rate_meter_limiter_unit;
    import frmlu_pkg::*;

    localparam logic [APB_ADDR_W-1:0] MAX_FPS_ADDR = {REG_MAX_FPS, 2'b00};
    localparam int PHASE_ITEMS = 240;
    localparam int NUM_PHASES  = 6;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [TS_W-1:0]       s_tdata;   // [31:0] now_ms
    logic                  s_tuser;   // [0] req_type
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;   // [21:0] fps_q8, [31:22] delay_ms
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatch_count;
    int pending_count;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          items_sent     = 0;
    logic [TS_W-1:0] clock_ms;
    int unsigned budget_ms;

    frame_rate_meter_limiter_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    frame_rate_meter_limiter_checker rate_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .mismatch_count(mismatch_count),
        .pending_count (pending_count)
    );

    always #6 aclk = ~aclk;

    // The result side stalls at random according to the current phase.
    always @(posedge aclk) begin
        m_tready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Offers one item after a random gap and returns at the edge that takes it.
    task automatic send_item(input logic kind, input logic [TS_W-1:0] ts);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= ts;
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        items_sent++;
    endtask

    // Stops the input side and waits for every queued result.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_count != 0);
        @(posedge aclk);
    endtask

    task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                              input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        while (!pready) @(negedge aclk);
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // One frame: a start item, then an end item some milliseconds later.
    task automatic send_frame(input int unsigned frame_ms);
        send_item(REQ_START, clock_ms);
        send_item(REQ_END, clock_ms + frame_ms);
        clock_ms = clock_ms + frame_ms + $urandom_range(0, 40);
    endtask

    initial begin
        logic [CFG_W-1:0] limit;
        int               mid_mark;
        bit               paused;
        int unsigned      roll;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= REQ_START;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed frames at the reset limit of 60 fps (16 ms budget).
        // An end with no start since reset, and an all-zero window.
        send_item(REQ_END, 32'd5);
        send_item(REQ_START, 32'd100);
        send_item(REQ_END, 32'd110);
        // Two ends at the same time give a zero interval.
        send_item(REQ_END, 32'd110);
        // Frame time exactly at the budget, then one below it.
        send_item(REQ_START, 32'd200);
        send_item(REQ_END, 32'd216);
        send_item(REQ_START, 32'd300);
        send_item(REQ_END, 32'd315);
        // Timestamps wrapping through zero.
        send_item(REQ_START, 32'hFFFF_FFF8);
        send_item(REQ_END, 32'h0000_0004);
        // Intervals just beyond and exactly at saturation.
        send_item(REQ_END, 32'h0001_0004);
        send_item(REQ_END, 32'h0002_0003);
        // Largest timestamp with a zero frame time.
        send_item(REQ_START, 32'hFFFF_FFFF);
        send_item(REQ_END, 32'hFFFF_FFFF);
        // A start later than the end, so the frame time wraps.
        send_item(REQ_START, 32'h0000_0010);
        send_item(REQ_END, 32'h0000_0005);
        // Two starts in a row, then an end.
        send_item(REQ_START, 32'h0000_0020);
        send_item(REQ_START, 32'h0000_0028);
        send_item(REQ_END, 32'h0000_0030);
        send_item(REQ_END, 32'h0000_0031);
        send_item(REQ_END, 32'h0000_0032);
        send_item(REQ_END, 32'h0000_0040);

        clock_ms = 32'h0000_1000;
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            repeat (100) @(posedge aclk);
            case (p)
                0: limit = '0;
                1: limit = CFG_W'(1);
                2: limit = CFG_W'(BUDGET_MS);
                3: limit = '1;
                4: limit = MAX_FPS_RESET;
                default: limit = CFG_W'($urandom_range(1, 1023));
            endcase
            apb_access(1'b1, MAX_FPS_ADDR, APB_DATA_W'(limit));
            apb_access(1'b0, MAX_FPS_ADDR, '0);
            budget_ms = BUDGET_MS / ((limit == '0) ? 1 : limit);

            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 48; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 48; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase

            mid_mark = items_sent + PHASE_ITEMS / 2;
            paused   = 0;
            for (int n = items_sent + PHASE_ITEMS; items_sent < n; ) begin
                // Halfway through, let the meter empty before going on.
                if (!paused && items_sent >= mid_mark) begin
                    drain_results();
                    paused = 1;
                end
                roll = $urandom_range(0, 99);
                if (roll < 80) begin
                    send_frame($urandom_range(0, budget_ms + 8));
                end else if (roll < 84) begin
                    clock_ms = $urandom;
                end else if (roll < 88) begin
                    clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 60);
                end else if (roll < 91) begin
                    clock_ms = clock_ms + $urandom_range(60000, 70000);
                end else if (roll < 96) begin
                    send_item(logic'($urandom_range(0, 1)), $urandom);
                end else begin
                    send_item(REQ_END, clock_ms);
                    clock_ms = clock_ms + $urandom_range(0, 3);
                    send_item(REQ_END, clock_ms);
                end
            end
        end

        drain_results();
        repeat (100) @(posedge aclk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("frame_rate_meter_limiter_unit regression: pass");
        end else begin
            $display("frame_rate_meter_limiter_unit regression: fail");
        end
        $finish;
    end

    // Hard stop in case the block hangs.
    initial begin
        #(20_000_000);
        $display("frame_rate_meter_limiter_unit regression: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/frmlu_pkg.sv
design/frame_rate_meter_limiter_unit.sv
sim/frame_rate_meter_limiter_checker.sv
sim/tb_frame_rate_meter_limiter_unit.sv
